// File: rtl/itoa_pkg.sv
// Shared types, constants and the digit glyph table for the integer to ASCII converter.
package itoa_pkg;

  localparam int unsigned VALUE_IN_W    = 64;
  localparam int unsigned VALUE_W_DEF   = 64;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned CHAR_W        = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } itoa_state_e;

  // Maps a digit value to its character, lower-case letters above nine.
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] glyph;
    glyph = 7'd48;
    case (digit)
      4'd0:    glyph = 7'd48;
      4'd1:    glyph = 7'd49;
      4'd2:    glyph = 7'd50;
      4'd3:    glyph = 7'd51;
      4'd4:    glyph = 7'd52;
      4'd5:    glyph = 7'd53;
      4'd6:    glyph = 7'd54;
      4'd7:    glyph = 7'd55;
      4'd8:    glyph = 7'd56;
      4'd9:    glyph = 7'd57;
      4'd10:   glyph = 7'd97;
      4'd11:   glyph = 7'd98;
      4'd12:   glyph = 7'd99;
      4'd13:   glyph = 7'd100;
      4'd14:   glyph = 7'd101;
      default: glyph = 7'd102;
    endcase
    return glyph;
  endfunction

endpackage

// File: rtl/integer_to_ascii_radix.sv
// Top level of the signed integer to ASCII text converter with a programmable radix.
//
// Input channel: value_i with in_valid_i / in_stall_o; an item is taken when valid is high
// and stall is low. Only the low VALUE_WIDTH bits count, read as two's complement.
// Output channel: one character per transfer on character_o with out_valid_o / out_stall_i;
// a minus sign comes first for negative values, then the digits, most significant first.
// last_char_o marks the final character of each number. Zero gives the single digit "0".
// Configuration: radix_we_i writes radix_i (2 to 16, saturated outside); the user must
// write it only while idle, as the block itself does not enforce this.
// Operation: each digit comes from a bit-serial restoring division by the radix, one
// quotient bit per cycle, and each character then passes through the registered digit
// memory read. One item is worked at a time.
// The input is stalled until the last character has entered the output register, and a
// new item is taken while that character still waits for the receiver.
// A stalled receiver holds the output register and pauses character emission.
// Reset sets the radix to 10 and empties the pipeline; the digit memory is not cleared.
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  radix_we_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_IN_W-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     character_o,
  output logic                  last_char_o
);

  localparam int unsigned MAG_W = VALUE_WIDTH - 1;
  localparam int unsigned AW    = $clog2(MAG_W);
  localparam int unsigned BW    = $clog2(MAG_W);

  itoa_state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_eff;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [BW-1:0]      bit_q, bit_d;
  logic [AW:0]        ndig_q, ndig_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic [DIGIT_W-1:0] mem_q [MAG_W];
  logic [DIGIT_W-1:0] rd_data_q;

  logic [VALUE_WIDTH-1:0] in_val;
  logic [VALUE_WIDTH-1:0] in_neg;
  logic [MAG_W-1:0]       in_mag;
  logic                   in_sign;
  logic                   in_take;
  logic                   out_free;
  logic [RADIX_W-1:0]     trial;
  logic                   q_bit;
  logic [RADIX_W-1:0]     trial_sub;
  logic [DIGIT_W-1:0]     rem_next;
  logic [MAG_W-1:0]       step_mag;
  logic                   last_bit;
  logic                   digit_we;

  assign radix_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
                     (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

  // Magnitude of the incoming value; the most negative value saturates.
  assign in_val  = value_i[VALUE_WIDTH-1:0];
  assign in_sign = in_val[VALUE_WIDTH-1];
  assign in_neg  = ~in_val + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
  always_comb begin
    if (!in_sign) begin
      in_mag = in_val[MAG_W-1:0];
    end else if (in_val[MAG_W-1:0] == '0) begin
      in_mag = '1;
    end else begin
      in_mag = in_neg[MAG_W-1:0];
    end
  end

  // One step of the restoring division: bring down the next dividend bit.
  assign trial     = {rem_q, mag_q[MAG_W-1]};
  assign q_bit     = (trial >= radix_eff);
  assign trial_sub = trial - radix_eff;
  assign rem_next  = q_bit ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign step_mag  = {mag_q[MAG_W-2:0], q_bit};
  assign last_bit  = (bit_q == BW'(MAG_W - 1));

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (last_bit && step_mag == '0) state_d = neg_q ? ST_SIGN : ST_READ;
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    mag_d       = mag_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    ndig_d      = ndig_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    digit_we    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          mag_d  = in_mag;
          neg_d  = in_sign;
          rem_d  = '0;
          bit_d  = '0;
          ndig_d = '0;
        end
      end
      ST_DIV: begin
        mag_d = step_mag;
        rem_d = rem_next;
        bit_d = bit_q + BW'(1);
        if (last_bit) begin
          digit_we = 1'b1;
          ndig_d   = ndig_q + (AW+1)'(1);
          idx_d    = ndig_q[AW-1:0];
          bit_d    = '0;
          rem_d    = '0;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = ASCII_MINUS;
          last_d      = 1'b0;
        end
      end
      ST_READ: begin
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_glyph(rd_data_q);
          last_d      = (idx_q == '0);
          if (idx_q != '0) idx_d = idx_q - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      ndig_q      <= '0;
      bit_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ndig_q      <= ndig_d;
      bit_q       <= bit_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      if (radix_we_i) radix_q <= radix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Digit memory: least significant digit at address zero.
  always_ff @(posedge clk_i) begin
    if (digit_we) mem_q[ndig_q[AW-1:0]] <= rem_next;
    rd_data_q <= mem_q[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

`ifndef ASSERT_OFF
  a_take_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == ST_DIV)
    else $error("accepted item did not start the division");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> {1'b0, rem_q} < radix_eff)
    else $error("partial remainder reached the radix");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= (AW+1)'(MAG_W))
    else $error("digit count exceeds the digit memory");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_free && idx_q == '0 |=> out_valid_o && last_char_o)
    else $error("final digit not flagged as last");
`endif

endmodule
